/* rtl/pgsa_pkg.sv */
// ----------------------------------------------------------------------------
// pgsa_pkg: PWM generator share allocator shared definitions
// Pool sizes, code limits, sequencer states and the pool control words.
// ----------------------------------------------------------------------------
`default_nettype none

package pgsa_pkg;

  localparam int NUM_GENERATORS = 8;
  localparam int NUM_CHANNELS   = 33;
  localparam int GEN_W          = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;

  localparam logic [NUM_CHANNELS-1:0] CHAN_ONE = NUM_CHANNELS'(1);
  localparam logic [GEN_W-1:0]        GEN_LAST = GEN_W'(NUM_GENERATORS - 1);

  localparam logic [31:0] PERIOD_LO_NS = 32'd4000000;
  localparam logic [31:0] PERIOD_HI_NS = 32'd1000000000;
  // 25 * period / 100000000 reduces to period / 4000000
  localparam logic [31:0] PCODE_DIV    = 32'd4000000;
  localparam logic [7:0]  FULL_DUTY    = 8'd255;
  localparam logic [7:0]  PCODE_MIN    = 8'd1;
  localparam logic [7:0]  PCODE_MAX    = 8'd250;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_BUSY  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DUTY,
    S_PERIOD,
    S_EVAL,
    S_DETACH,
    S_SCAN,
    S_ATTACH,
    S_RESPOND
  } state_t;

  typedef enum logic [1:0] {
    POOL_NOP,
    POOL_SCAN,
    POOL_DETACH,
    POOL_ATTACH
  } pool_cmd_t;

  typedef struct packed {
    pool_cmd_t               cmd;
    logic [NUM_CHANNELS-1:0] chan_bit;
    logic [7:0]              dcode;
    logic [7:0]              pcode;
    logic [GEN_W-1:0]        target;
  } pool_ctrl_t;

  typedef struct packed {
    logic             scan_done;
    logic             match_found;
    logic [GEN_W-1:0] match_idx;
    logic             free_found;
    logic [GEN_W-1:0] free_idx;
    logic             cur_found;
    logic [GEN_W-1:0] cur_idx;
  } pool_stat_t;

  // generator number as reported on the 3-bit result field
  function automatic logic [2:0] gen_field(input logic [GEN_W-1:0] idx);
    logic [GEN_W+2:0] wide;
    wide = {3'b000, idx};
    return wide[2:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/pwm_generator_share_allocator.sv */
// ----------------------------------------------------------------------------
// pwm_generator_share_allocator: shares PWM generators among channels
// Converts duty and period to codes on a shared divider, then scans the
// generator pool to attach, detach or report the channel.
// ----------------------------------------------------------------------------
//  channel  | handshake     | words
//  ---------+---------------+----------------------------------------------
//  request  | start / busy  | action channel enabled duty_ns period_len inverted
//  result   | done strobe   | status generator attached duty_code period_code
//
// done comes after S_CHECK for an ignored or rejected request, after S_DETACH
// for a release, and for a zero duty or an apply after two divider passes
// (duty, then period), S_EVAL, then S_DETACH or a scan of all eight pool
// generators and, if there is room, S_ATTACH; S_IDLE precedes the next request.
// busy is high from the cycle after a request is taken until the done cycle.
// Reset clears the user sets of all generators; no clearing pass is needed.
// The result is held for the single done cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_generator_share_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action,
  input  wire logic [5:0]  channel,
  input  wire logic        enabled,
  input  wire logic [31:0] duty_ns,
  input  wire logic [31:0] period_len,
  input  wire logic        inverted,
  output logic             done,
  output logic [1:0]       status,
  output logic [2:0]       generator,
  output logic             attached,
  output logic [7:0]       duty_code,
  output logic [7:0]       period_code
);

  pgsa_pkg::state_t     state;
  pgsa_pkg::state_t     state_next;
  pgsa_pkg::pool_ctrl_t pool_ctrl;
  pgsa_pkg::pool_stat_t pool_stat;
  pgsa_pkg::status_t    res_status;

  logic        act;
  logic [5:0]  chan;
  logic        en;
  logic [31:0] duty;
  logic [31:0] per;
  logic        inv;

  logic [2:0]  res_gen;
  logic        res_att;
  logic [7:0]  dcode;
  logic [7:0]  pcode;
  logic [pgsa_pkg::GEN_W-1:0] target;

  logic        chan_ok;
  logic        per_ok;
  logic [31:0] duty_eff;
  logic [39:0] duty_num;
  logic [pgsa_pkg::NUM_CHANNELS-1:0] chan_bit;

  logic        div_start;
  logic [39:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [7:0]  div_quot;

  assign chan_ok  = ({1'b0, chan} < 7'(pgsa_pkg::NUM_CHANNELS));
  assign per_ok   = (per >= pgsa_pkg::PERIOD_LO_NS) && (per <= pgsa_pkg::PERIOD_HI_NS);
  assign duty_eff = en ? duty : 32'd0;
  // 255 * duty as (duty << 8) - duty
  assign duty_num = {duty_eff, 8'b0} - {8'b0, duty_eff};
  assign chan_bit = pgsa_pkg::CHAN_ONE << chan;

  pgsa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  pgsa_pool u_pool (
    .clk  (clk),
    .rst  (rst),
    .ctrl (pool_ctrl),
    .stat (pool_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pgsa_pkg::S_IDLE: begin
        if (start) state_next = pgsa_pkg::S_CHECK;
      end
      pgsa_pkg::S_CHECK: begin
        if (!chan_ok)     state_next = pgsa_pkg::S_RESPOND;
        else if (act)     state_next = pgsa_pkg::S_DETACH;
        else if (!per_ok) state_next = pgsa_pkg::S_RESPOND;
        else              state_next = pgsa_pkg::S_DUTY;
      end
      pgsa_pkg::S_DUTY: begin
        if (div_done) state_next = pgsa_pkg::S_PERIOD;
      end
      pgsa_pkg::S_PERIOD: begin
        if (div_done) state_next = pgsa_pkg::S_EVAL;
      end
      pgsa_pkg::S_EVAL: begin
        state_next = (dcode == 8'd0) ? pgsa_pkg::S_DETACH : pgsa_pkg::S_SCAN;
      end
      pgsa_pkg::S_DETACH: begin
        state_next = pgsa_pkg::S_RESPOND;
      end
      pgsa_pkg::S_SCAN: begin
        if (pool_stat.scan_done) begin
          if (pool_stat.match_found || pool_stat.free_found) begin
            state_next = pgsa_pkg::S_ATTACH;
          end else begin
            state_next = pgsa_pkg::S_RESPOND;
          end
        end
      end
      pgsa_pkg::S_ATTACH: begin
        state_next = pgsa_pkg::S_RESPOND;
      end
      pgsa_pkg::S_RESPOND: begin
        state_next = pgsa_pkg::S_IDLE;
      end
      default: state_next = pgsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy               = (state != pgsa_pkg::S_IDLE);
    done               = (state == pgsa_pkg::S_RESPOND);
    div_start          = 1'b0;
    div_num            = duty_num;
    div_den            = per;
    pool_ctrl.cmd      = pgsa_pkg::POOL_NOP;
    pool_ctrl.chan_bit = chan_bit;
    pool_ctrl.dcode    = dcode;
    pool_ctrl.pcode    = pcode;
    pool_ctrl.target   = target;
    unique case (state)
      pgsa_pkg::S_CHECK: begin
        div_start = chan_ok && !act && per_ok;
      end
      pgsa_pkg::S_DUTY: begin
        // chain the period pass right behind the duty pass
        div_start = div_done;
        div_num   = {8'b0, per};
        div_den   = pgsa_pkg::PCODE_DIV;
      end
      pgsa_pkg::S_EVAL: begin
        if (dcode != 8'd0) pool_ctrl.cmd = pgsa_pkg::POOL_SCAN;
      end
      pgsa_pkg::S_DETACH: begin
        pool_ctrl.cmd = pgsa_pkg::POOL_DETACH;
      end
      pgsa_pkg::S_ATTACH: begin
        pool_ctrl.cmd = pgsa_pkg::POOL_ATTACH;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act  <= action;
      chan <= channel;
      en   <= enabled;
      duty <= duty_ns;
      per  <= period_len;
      inv  <= inverted;
    end
    case (state)
      pgsa_pkg::S_CHECK: begin
        res_status <= (chan_ok && !act && !per_ok) ? pgsa_pkg::STATUS_RANGE
                                                   : pgsa_pkg::STATUS_OK;
        res_gen    <= 3'd0;
        res_att    <= 1'b0;
        dcode      <= 8'd0;
        pcode      <= 8'd0;
      end
      pgsa_pkg::S_DUTY: begin
        if (div_done) dcode <= inv ? (pgsa_pkg::FULL_DUTY - div_quot) : div_quot;
      end
      pgsa_pkg::S_PERIOD: begin
        if (div_done) begin
          if (div_quot < pgsa_pkg::PCODE_MIN)      pcode <= pgsa_pkg::PCODE_MIN;
          else if (div_quot > pgsa_pkg::PCODE_MAX) pcode <= pgsa_pkg::PCODE_MAX;
          else                                     pcode <= div_quot;
        end
      end
      pgsa_pkg::S_SCAN: begin
        if (pool_stat.scan_done) begin
          if (pool_stat.match_found) begin
            target  <= pool_stat.match_idx;
            res_gen <= pgsa_pkg::gen_field(pool_stat.match_idx);
            res_att <= 1'b1;
          end else if (pool_stat.free_found) begin
            target  <= pool_stat.free_idx;
            res_gen <= pgsa_pkg::gen_field(pool_stat.free_idx);
            res_att <= 1'b1;
          end else begin
            // no room: report where the channel still sits
            res_status <= pgsa_pkg::STATUS_BUSY;
            if (pool_stat.cur_found) begin
              res_gen <= pgsa_pkg::gen_field(pool_stat.cur_idx);
              res_att <= 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign status      = res_status;
  assign generator   = res_gen;
  assign attached    = res_att;
  assign duty_code   = dcode;
  assign period_code = pcode;

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but busy stayed low");

  a_range_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status == pgsa_pkg::STATUS_RANGE) |->
      (!attached && duty_code == 8'd0 && period_code == 8'd0))
    else $error("range reject carries computed fields");

  a_attach_codes: assert property (@(posedge clk) disable iff (rst)
    (done && attached && status == pgsa_pkg::STATUS_OK) |->
      (duty_code != 8'd0 && period_code != 8'd0))
    else $error("attached with a zero code");

endmodule

`default_nettype wire

/* rtl/pgsa_div.sv */
// ----------------------------------------------------------------------------
// pgsa_div: shared restoring divider
// 40-bit by 32-bit, one compare-subtract per cycle, 8-bit quotient
// saturated to 255. Nine steps; done pulses the cycle after the last.
// ----------------------------------------------------------------------------
`default_nettype none

module pgsa_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [39:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [7:0]       quot
);

  logic [39:0] rem;
  logic [39:0] dsh;
  logic [8:0]  q;
  logic [3:0]  cnt;
  logic        running;
  logic        ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == 4'd0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, 8'b0};
      q   <= '0;
      cnt <= 4'd8;
    end else if (running) begin
      // first step tests den << 8: a set bit there means quotient >= 256
      if (ge) begin
        rem <= rem - dsh;
      end
      q   <= {q[7:0], ge};
      dsh <= {1'b0, dsh[39:1]};
      cnt <= cnt - 4'd1;
    end
  end

  assign quot = q[8] ? 8'hFF : q[7:0];

endmodule

`default_nettype wire

/* rtl/pgsa_pool.sv */
// ----------------------------------------------------------------------------
// pgsa_pool: generator table and scanner
// Holds user sets and codes of each generator; scans one generator per
// cycle for a match, a free one and the channel's current one.
// ----------------------------------------------------------------------------
`default_nettype none

module pgsa_pool (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pgsa_pkg::pool_ctrl_t ctrl,
  output pgsa_pkg::pool_stat_t      stat
);

  logic [pgsa_pkg::NUM_CHANNELS-1:0] users [pgsa_pkg::NUM_GENERATORS];
  logic [7:0]                        gduty [pgsa_pkg::NUM_GENERATORS];
  logic [7:0]                        gper  [pgsa_pkg::NUM_GENERATORS];

  logic [pgsa_pkg::GEN_W-1:0]        idx;
  logic                              scanning;
  logic [pgsa_pkg::NUM_CHANNELS-1:0] u;
  logic                              hit_match;
  logic                              hit_free;
  logic                              hit_cur;

  always_comb begin
    u         = users[idx];
    hit_match = (|u) &&
                ((gduty[idx] == ctrl.dcode && gper[idx] == ctrl.pcode) ||
                 (ctrl.dcode == pgsa_pkg::FULL_DUTY && gduty[idx] == pgsa_pkg::FULL_DUTY));
    hit_free  = ((u & ~ctrl.chan_bit) == '0);
    hit_cur   = |(u & ctrl.chan_bit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < pgsa_pkg::NUM_GENERATORS; g++) begin
        users[g] <= '0;
      end
      scanning         <= 1'b0;
      idx              <= '0;
      stat.scan_done   <= 1'b0;
      stat.match_found <= 1'b0;
      stat.free_found  <= 1'b0;
      stat.cur_found   <= 1'b0;
    end else begin
      stat.scan_done <= 1'b0;
      unique case (ctrl.cmd)
        pgsa_pkg::POOL_SCAN: begin
          scanning         <= 1'b1;
          idx              <= '0;
          stat.match_found <= 1'b0;
          stat.free_found  <= 1'b0;
          stat.cur_found   <= 1'b0;
        end
        pgsa_pkg::POOL_DETACH: begin
          for (int g = 0; g < pgsa_pkg::NUM_GENERATORS; g++) begin
            users[g] <= users[g] & ~ctrl.chan_bit;
          end
        end
        pgsa_pkg::POOL_ATTACH: begin
          for (int g = 0; g < pgsa_pkg::NUM_GENERATORS; g++) begin
            if (pgsa_pkg::GEN_W'(g) == ctrl.target) begin
              users[g] <= users[g] | ctrl.chan_bit;
            end else begin
              users[g] <= users[g] & ~ctrl.chan_bit;
            end
          end
        end
        default: begin
        end
      endcase
      if (scanning) begin
        // keep the lowest index of each kind
        if (hit_match && !stat.match_found) begin
          stat.match_found <= 1'b1;
          stat.match_idx   <= idx;
        end
        if (hit_free && !stat.free_found) begin
          stat.free_found <= 1'b1;
          stat.free_idx   <= idx;
        end
        if (hit_cur && !stat.cur_found) begin
          stat.cur_found <= 1'b1;
          stat.cur_idx   <= idx;
        end
        if (idx == pgsa_pkg::GEN_LAST) begin
          scanning       <= 1'b0;
          stat.scan_done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmd == pgsa_pkg::POOL_ATTACH) begin
      gduty[ctrl.target] <= ctrl.dcode;
      gper[ctrl.target]  <= ctrl.pcode;
    end
  end

endmodule

`default_nettype wire
